FILE: hdl/flbt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the failure lockout backoff table.
// No dependencies; the controller, datapath and top level import this package.

package flbt_pkg;

   // Operation codes carried in the request opcode field.
   typedef enum logic [2:0] {
      OP_CHECK  = 3'd0,
      OP_RECORD = 3'd1,
      OP_DELETE = 3'd2,
      OP_READ   = 3'd3,
      OP_SWEEP  = 3'd4
   } flbt_op_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_LIMITER_ON   = 3'd0;
   localparam logic [2:0] CSR_ATTEMPTS     = 3'd1;
   localparam logic [2:0] CSR_BASE_LOCK    = 3'd2;
   localparam logic [2:0] CSR_LOCK_CAP     = 3'd3;
   localparam logic [2:0] CSR_GROWTH       = 3'd4;

   // Backoff accumulator: seconds with 16 fraction bits, saturating at 2^41.
   localparam int          ACC_W     = 42;
   localparam int          MUL_SPLIT = 21;
   localparam int          PROD_W    = MUL_SPLIT + 16;
   localparam logic [ACC_W-1:0] ACC_SAT = 42'h200_0000_0000;

   localparam logic [6:0]  REMOVED_MAX = 7'd127;
   localparam logic [7:0]  FAILS_MAX   = 8'hFF;
   localparam logic [23:0] WAIT_MAX    = 24'hFF_FFFF;

   typedef struct packed {
      logic        limiter_on;
      logic [7:0]  attempts_before_lock;
      logic [23:0] base_lock_sec;
      logic [23:0] lock_cap_sec;
      logic [15:0] growth_factor_q8;
   } flbt_cfg_type;

   // One table record as stored in the RAM.
   typedef struct packed {
      logic        valid;
      logic [7:0]  fails;
      logic [31:0] lock_end;
      logic [31:0] last_fail;
      logic [31:0] first_fail;
   } flbt_entry_type;

   typedef struct packed {
      logic [23:0] wait_seconds;
      logic        entry_present;
      logic [7:0]  fail_total;
      logic [31:0] locked_until_sec;
      logic [31:0] last_fail_time;
      logic [31:0] first_fail_time;
      logic [6:0]  removed_count;
   } flbt_result_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_wr;
      logic load_item;
      logic key_rd;
      logic eval;
      logic mul_lo;
      logic mul_hi;
      logic acc_upd;
      logic dur;
      logic commit;
      logic swp_rd;
      logic swp_ev;
      logic out_load;
   } flbt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] op;
      logic       rec_lock;
      logic       steps_zero;
      logic       idx_last;
   } flbt_status_type;

endpackage

FILE: hdl/flbt_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module flbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/flbt_ctrl.sv
`timescale 1ns / 1ps
// Controller of the failure lockout table: sequences clear pass, lookups,
// the backoff multiply loop, the sweep and the result handoff. Uses flbt_pkg.

module flbt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  flbt_pkg::flbt_status_type status,
   output flbt_pkg::flbt_cmd_type    cmd
);

   import flbt_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_LOOP,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACC,
      ST_DUR,
      ST_COMMIT,
      ST_SWEEP_RD,
      ST_SWEEP_EV,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.idx_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.key_rd = 1'b1;
            case (status.op)
               OP_CHECK, OP_RECORD, OP_DELETE, OP_READ: state_in = ST_EVAL;
               OP_SWEEP: state_in = ST_SWEEP_RD;
               default:  state_in = ST_FINISH;
            endcase
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.rec_lock ? ST_LOOP : ST_FINISH;
         end
         ST_LOOP: begin
            state_in = status.steps_zero ? ST_DUR : ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_upd = 1'b1;
            state_in    = ST_LOOP;
         end
         ST_DUR: begin
            cmd.dur  = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_SWEEP_RD: begin
            cmd.swp_rd = 1'b1;
            state_in   = ST_SWEEP_EV;
         end
         ST_SWEEP_EV: begin
            cmd.swp_ev = 1'b1;
            state_in   = status.idx_last ? ST_FINISH : ST_SWEEP_RD;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Never overwrite a word that the receiver has not taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten while stalled");

   // A new result appears only as the handoff out of the finish state.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result valid raised outside finish");

   // Accepting a word always starts the table lookup.
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_READ))
      else $error("accepted word did not start a lookup");

endmodule

FILE: hdl/flbt_datapath.sv
`timescale 1ns / 1ps
// Datapath of the failure lockout table: item register, record RAM, backoff
// multiplier, sweep counter and result registers. Uses flbt_pkg and flbt_ram.

module flbt_datapath #(
   parameter int NUM_KEYS          = 64,
   parameter int MAX_BACKOFF_STEPS = 10,
   parameter int IDLE_LIMIT_SEC    = 3600
) (
   input  logic                      clock,
   input  logic                      reset,
   input  flbt_pkg::flbt_cmd_type    cmd,
   output flbt_pkg::flbt_status_type status,
   input  flbt_pkg::flbt_cfg_type    cfg,
   input  logic [2:0]                req_opcode,
   input  logic [5:0]                req_key_index,
   input  logic [31:0]               req_now_sec,
   output flbt_pkg::flbt_result_type rsp_word
);

   import flbt_pkg::*;

   localparam int KEY_W  = $clog2(NUM_KEYS);
   localparam int STEP_W = $clog2(MAX_BACKOFF_STEPS + 1);
   localparam int ENT_W  = $bits(flbt_entry_type);

   // Item under work.
   logic [2:0]  item_op_ff, item_op_in;
   logic [5:0]  item_key_ff, item_key_in;
   logic [31:0] item_now_ff, item_now_in;

   // Table walk index for clear pass and sweep.
   logic [KEY_W-1:0] idx_ff, idx_in;
   logic             idx_last;

   // Record RAM ports.
   logic             wr_en;
   logic [KEY_W-1:0] wr_addr;
   flbt_entry_type   wr_data;
   logic             rd_en;
   logic [KEY_W-1:0] rd_addr;
   flbt_entry_type   rd_entry;
   logic [ENT_W-1:0] rd_raw;

   logic [KEY_W-1:0] key_addr;
   logic             key_ok, hit, active;

   // Failure update terms.
   logic [7:0]  f0, f1, fails_new, steps_n;
   logic [31:0] l0, l1, first0;
   logic        lock_needed;
   logic [31:0] check_w;

   // Working registers of a record that starts a lockout.
   logic [7:0]        wk_fails_ff, wk_fails_in;
   logic [31:0]       wk_first_ff, wk_first_in;
   logic [STEP_W-1:0] steps_ff, steps_in;

   // Backoff arithmetic.
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [PROD_W-1:0] prod_lo_ff, prod_lo_in;
   logic [PROD_W-1:0] prod_hi_ff, prod_hi_in;
   logic [PROD_W+MUL_SPLIT-1:0] prod_full;
   logic [PROD_W+MUL_SPLIT-9:0] prod_shr;
   logic [23:0]       dur_ff, dur_in;
   logic [32:0]       end_sum;
   logic [31:0]       lock_sat;

   // Sweep test.
   logic [32:0] idle_diff;
   logic        drop;

   flbt_result_type res_ff, res_in;
   flbt_result_type out_ff, out_in;

   assign key_addr = KEY_W'(item_key_ff);
   assign key_ok   = (32'(item_key_ff) < NUM_KEYS);
   assign rd_entry = flbt_entry_type'(rd_raw);
   assign hit      = key_ok && rd_entry.valid;
   assign active   = cfg.limiter_on && key_ok;
   assign idx_last = (idx_ff == KEY_W'(NUM_KEYS - 1));

   // Record update: fresh record, then expired lock restart, then count.
   always_comb begin
      if (rd_entry.valid) begin
         f0     = rd_entry.fails;
         l0     = rd_entry.lock_end;
         first0 = rd_entry.first_fail;
      end else begin
         f0     = 8'd0;
         l0     = 32'd0;
         first0 = item_now_ff;
      end
      if (l0 != 32'd0 && item_now_ff >= l0) begin
         f1 = 8'd0;
         l1 = 32'd0;
      end else begin
         f1 = f0;
         l1 = l0;
      end
      fails_new   = (f1 == FAILS_MAX) ? f1 : f1 + 8'd1;
      lock_needed = (fails_new >= cfg.attempts_before_lock);
      steps_n     = fails_new - cfg.attempts_before_lock;
      check_w     = rd_entry.lock_end - item_now_ff;
   end

   // Sweep drop test for the entry read at idx.
   assign idle_diff = {1'b0, item_now_ff} - {1'b0, rd_entry.last_fail};
   assign drop = rd_entry.valid
              && (rd_entry.lock_end == 32'd0 || item_now_ff >= rd_entry.lock_end)
              && (item_now_ff > rd_entry.last_fail)
              && (idle_diff[31:0] > 32'(IDLE_LIMIT_SEC));

   // Multiply in two halves: low and high parts of the accumulator.
   assign prod_lo_in = {{(PROD_W-MUL_SPLIT){1'b0}}, acc_ff[MUL_SPLIT-1:0]}
                     * {{(PROD_W-16){1'b0}}, cfg.growth_factor_q8};
   assign prod_hi_in = {{(PROD_W-MUL_SPLIT){1'b0}}, acc_ff[ACC_W-1:MUL_SPLIT]}
                     * {{(PROD_W-16){1'b0}}, cfg.growth_factor_q8};
   assign prod_full  = {prod_hi_ff, {MUL_SPLIT{1'b0}}}
                     + {{MUL_SPLIT{1'b0}}, prod_lo_ff};
   assign prod_shr   = prod_full[PROD_W+MUL_SPLIT-1:8];

   assign end_sum  = {1'b0, item_now_ff} + {9'd0, dur_ff};
   assign lock_sat = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];

   always_comb begin
      item_op_in  = item_op_ff;
      item_key_in = item_key_ff;
      item_now_in = item_now_ff;
      idx_in      = idx_ff;
      wk_fails_in = wk_fails_ff;
      wk_first_in = wk_first_ff;
      steps_in    = steps_ff;
      acc_in      = acc_ff;
      dur_in      = dur_ff;
      res_in      = res_ff;
      out_in      = out_ff;
      wr_en       = 1'b0;
      wr_addr     = key_addr;
      wr_data     = rd_entry;
      wr_data.valid = 1'b0;

      // Hold the item and clear the result on accept.
      if (cmd.load_item) begin
         item_op_in  = req_opcode;
         item_key_in = req_key_index;
         item_now_in = req_now_sec;
         res_in      = '0;
      end

      // Clear pass after reset: drop every record.
      if (cmd.clr_wr) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = '0;
      end

      if (cmd.clr_wr || cmd.swp_ev) begin
         idx_in = idx_last ? '0 : idx_ff + 1'b1;
      end

      if (cmd.eval) begin
         wk_fails_in = fails_new;
         wk_first_in = first0;
         steps_in    = (steps_n > 8'(MAX_BACKOFF_STEPS)) ? STEP_W'(MAX_BACKOFF_STEPS)
                                                         : STEP_W'(steps_n);
         acc_in      = {2'b00, cfg.base_lock_sec, 16'h0000};
         case (item_op_ff)
            OP_CHECK: begin
               if (cfg.limiter_on && hit) begin
                  res_in.entry_present = 1'b1;
                  if (rd_entry.lock_end != 32'd0 && item_now_ff < rd_entry.lock_end) begin
                     res_in.wait_seconds = (check_w[31:24] != 8'd0) ? WAIT_MAX
                                                                     : check_w[23:0];
                  end
               end
            end
            OP_RECORD: begin
               if (active && !lock_needed) begin
                  wr_en              = 1'b1;
                  wr_data.valid      = 1'b1;
                  wr_data.fails      = fails_new;
                  wr_data.lock_end   = l1;
                  wr_data.last_fail  = item_now_ff;
                  wr_data.first_fail = first0;
               end
            end
            OP_DELETE: begin
               wr_en = active;
            end
            OP_READ: begin
               if (hit) begin
                  res_in.entry_present    = 1'b1;
                  res_in.fail_total       = rd_entry.fails;
                  res_in.locked_until_sec = rd_entry.lock_end;
                  res_in.last_fail_time   = rd_entry.last_fail;
                  res_in.first_fail_time  = rd_entry.first_fail;
               end
            end
            default: ;
         endcase
      end

      // One backoff step: add partial products, drop 8 bits, saturate.
      if (cmd.acc_upd) begin
         acc_in   = (prod_shr > {8'd0, ACC_SAT}) ? ACC_SAT : prod_shr[ACC_W-1:0];
         steps_in = steps_ff - 1'b1;
      end

      if (cmd.dur) begin
         dur_in = (acc_ff > {2'b00, cfg.lock_cap_sec, 16'h0000}) ? cfg.lock_cap_sec
                                                                  : acc_ff[39:16];
      end

      if (cmd.commit) begin
         wr_en               = 1'b1;
         wr_data.valid       = 1'b1;
         wr_data.fails       = wk_fails_ff;
         wr_data.lock_end    = lock_sat;
         wr_data.last_fail   = item_now_ff;
         wr_data.first_fail  = wk_first_ff;
         res_in.wait_seconds = dur_ff;
      end

      if (cmd.swp_ev && drop) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         if (res_ff.removed_count != REMOVED_MAX) begin
            res_in.removed_count = res_ff.removed_count + 7'd1;
         end
      end

      if (cmd.out_load) begin
         out_in = res_ff;
      end
   end

   assign rd_en   = cmd.key_rd || cmd.swp_rd;
   assign rd_addr = cmd.swp_rd ? idx_ff : key_addr;

   flbt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (NUM_KEYS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      item_op_ff  <= item_op_in;
      item_key_ff <= item_key_in;
      item_now_ff <= item_now_in;
      wk_fails_ff <= wk_fails_in;
      wk_first_ff <= wk_first_in;
      steps_ff    <= steps_in;
      acc_ff      <= acc_in;
      prod_lo_ff  <= cmd.mul_lo ? prod_lo_in : prod_lo_ff;
      prod_hi_ff  <= cmd.mul_hi ? prod_hi_in : prod_hi_ff;
      dur_ff      <= dur_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
   end

   assign status.op         = item_op_ff;
   assign status.rec_lock   = (item_op_ff == OP_RECORD) && active && lock_needed;
   assign status.steps_zero = (steps_ff == '0);
   assign status.idx_last   = idx_last;
   assign rsp_word          = out_ff;

   // A lockout never ends before the failure that started it.
   a_commit_end: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (wr_data.lock_end >= item_now_ff))
      else $error("commit lock end below current time");

   // The accumulator never leaves its saturation range inside the loop.
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_lo |-> (acc_ff <= ACC_SAT))
      else $error("backoff accumulator above saturation");

   // The duration committed never exceeds the cap.
   a_dur_cap: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (dur_ff <= cfg.lock_cap_sec))
      else $error("lockout duration above cap");

   // Sweep only ever drops records.
   a_sweep_drops: assert property (@(posedge clock) disable iff (reset)
      (cmd.swp_ev && wr_en) |-> !wr_data.valid)
      else $error("sweep wrote a valid record");

endmodule

FILE: hdl/failure_lockout_backoff_table_unit.sv
`timescale 1ns / 1ps
// Top level of the failure lockout backoff table: configuration registers,
// controller and datapath. Uses flbt_pkg, flbt_ctrl and flbt_datapath.
//
// Usage
//  - Request channel (req_*): one word per operation: opcode (check, record
//    failure, delete, read, sweep), key index and current time in seconds.
//  - Response channel (rsp_*): exactly one word per request, in order. Fields
//    that an operation does not report are zero.
//  - CSR channel (csr_*): register index and write data; always ready. Write
//    only while the block holds no request in flight.
//  - Sequence after accept: a RAM read, an evaluate and the result handoff for
//    check, read, delete and a record that starts no lockout; a record that
//    starts a lockout adds n backoff steps (n at most MAX_BACKOFF_STEPS), each
//    a loop test, two partial products and an accumulate, then a final loop
//    test, the duration and the commit.
//    A sweep does one RAM read and one evaluate per record. One request is
//    in work at a time.
//  - Reset: a clear pass drops every record; req_ready stays
//    low during it. Configuration takes its default values.
//  - Stall: the response sits in an output register; the next request is
//    accepted and processed while it waits, and finishes once the receiver
//    takes the waiting word.

module failure_lockout_backoff_table_unit #(
   parameter int NUM_KEYS          = 64,
   parameter int MAX_BACKOFF_STEPS = 10,
   parameter int IDLE_LIMIT_SEC    = 3600
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [5:0]  req_key_index,
   input  logic [31:0] req_now_sec,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_wait_seconds,
   output logic        rsp_entry_present,
   output logic [7:0]  rsp_fail_total,
   output logic [31:0] rsp_locked_until_sec,
   output logic [31:0] rsp_last_fail_time,
   output logic [31:0] rsp_first_fail_time,
   output logic [6:0]  rsp_removed_count,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   import flbt_pkg::*;

   flbt_cfg_type    cfg_ff, cfg_in;
   flbt_cmd_type    cmd;
   flbt_status_type status;
   flbt_result_type rsp_word;

   // Configuration registers: always accept, ignore unknown indexes.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LIMITER_ON: cfg_in.limiter_on           = csr_wdata[0];
            CSR_ATTEMPTS:   cfg_in.attempts_before_lock = csr_wdata[7:0];
            CSR_BASE_LOCK:  cfg_in.base_lock_sec        = csr_wdata;
            CSR_LOCK_CAP:   cfg_in.lock_cap_sec         = csr_wdata;
            CSR_GROWTH:     cfg_in.growth_factor_q8     = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limiter_on           <= 1'b1;
         cfg_ff.attempts_before_lock <= 8'd5;
         cfg_ff.base_lock_sec        <= 24'd30;
         cfg_ff.lock_cap_sec         <= 24'd3600;
         cfg_ff.growth_factor_q8     <= 16'd512;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Sequence the operation.
   flbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Table, arithmetic and result registers.
   flbt_datapath #(
      .NUM_KEYS          (NUM_KEYS),
      .MAX_BACKOFF_STEPS (MAX_BACKOFF_STEPS),
      .IDLE_LIMIT_SEC    (IDLE_LIMIT_SEC)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .cfg           (cfg_ff),
      .req_opcode    (req_opcode),
      .req_key_index (req_key_index),
      .req_now_sec   (req_now_sec),
      .rsp_word      (rsp_word)
   );

   // Split the response word onto its ports.
   assign rsp_wait_seconds     = rsp_word.wait_seconds;
   assign rsp_entry_present    = rsp_word.entry_present;
   assign rsp_fail_total       = rsp_word.fail_total;
   assign rsp_locked_until_sec = rsp_word.locked_until_sec;
   assign rsp_last_fail_time   = rsp_word.last_fail_time;
   assign rsp_first_fail_time  = rsp_word.first_fail_time;
   assign rsp_removed_count    = rsp_word.removed_count;

endmodule
